### design/uart_register_datagram_codec_assert.svh
// Assertion macros shared by the checker of the datagram codec.
// No dependencies; expects i_clk and i_rst_n in the scope of use.
`ifndef UART_REGISTER_DATAGRAM_CODEC_ASSERT_SVH
`define UART_REGISTER_DATAGRAM_CODEC_ASSERT_SVH

// same-cycle implication
`define URDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define URDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/uartrdc_pkg.sv
// Package for the UART register datagram codec: codes, constants, CRC8 step.
// No dependencies.
`default_nettype none

package uartrdc_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic       WRITE_FLAG  = 1'b1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_REPLY = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SYNC   = 3'd1,
        ST_BAD_MASTER = 3'd2,
        ST_BAD_REG    = 3'd3,
        ST_BAD_CRC    = 3'd4
    } t_status;

    // one byte into the CRC, LSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ data[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/uart_register_datagram_codec.sv
// Top level of the UART register datagram codec: request builder and reply checker.
// Depends on uartrdc_pkg.
//
//  channel  | dir | tdata (low bit up)                         | tuser   | tlast
//  s_axis   | in  | reg_address[6:0] write_value[38:7] rx[46:39]| action  | -
//  m_axis   | out | tx_byte[7:0] reply_value[39:8] status[42:40]| kind    | last
//  cfg      | in  | node_address[7:0]                          | -       | -
//
// A reply check result passes through the byte buffer and the output register onto
// m_axis after its final byte is taken. A write request streams 8 bytes, a read 4,
// one per cycle from a byte buffer whose CRC runs along with the bytes sent; the
// next item is taken in the cycle the last byte moves to the output register.
// Synchronous active-low reset clears control state and the node address.
// An output stall holds the output register and then the byte buffer.
`default_nettype none

module uart_register_datagram_codec (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // reg_address, write_value, rx_byte, zero pad
    input  wire  [uartrdc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // action
    input  wire  [1:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // tx_byte, reply_value, reply_status, zero pad
    output logic [uartrdc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // out_kind
    output logic [0:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [7:0]                         i_cfg_data
);
    import uartrdc_pkg::*;

    logic [6:0]  in_reg;
    logic [31:0] in_value;
    logic [7:0]  in_rx;
    logic        in_fire;
    logic        out_free;
    logic        gen_emit;

    logic [7:0]  r_node;

    logic [2:0]  r_reply_count, n_reply_count;
    logic [7:0]  r_reply_crc, n_reply_crc;
    logic [31:0] r_reply_data, n_reply_data;
    t_status     r_reply_error, n_reply_error;
    logic [6:0]  r_expected, n_expected;

    // byte buffer feeding the output register
    logic [3:0]  r_gen_left, n_gen_left;
    logic        r_gen_kind, n_gen_kind;
    logic [55:0] r_gen_buf, n_gen_buf;
    logic [7:0]  r_gen_crc, n_gen_crc;
    logic [31:0] r_gen_value, n_gen_value;
    t_status     r_gen_status, n_gen_status;

    logic        r_out_valid, n_out_valid;
    logic        r_out_kind, n_out_kind;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;
    logic [31:0] r_out_value, n_out_value;
    t_status     r_out_status, n_out_status;

    t_status     chk_status;

    assign in_reg   = i_s_axis_tdata[6:0];
    assign in_value = i_s_axis_tdata[38:7];
    assign in_rx    = i_s_axis_tdata[46:39];

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign gen_emit = out_free && (r_gen_left != 4'd0);
    assign o_s_axis_tready = (r_gen_left == 4'd0) || ((r_gen_left == 4'd1) && out_free);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {5'd0, r_out_status, r_out_value, r_out_byte};

    always_comb begin
        n_reply_count = r_reply_count;
        n_reply_crc   = r_reply_crc;
        n_reply_data  = r_reply_data;
        n_reply_error = r_reply_error;
        n_expected    = r_expected;
        n_gen_left    = r_gen_left;
        n_gen_kind    = r_gen_kind;
        n_gen_buf     = r_gen_buf;
        n_gen_crc     = r_gen_crc;
        n_gen_value   = r_gen_value;
        n_gen_status  = r_gen_status;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        chk_status    = r_reply_error;

        if (out_free) begin
            n_out_valid = gen_emit;
        end
        if (gen_emit) begin
            n_gen_left = r_gen_left - 4'd1;
            n_out_kind = r_gen_kind;
            if (r_gen_kind == KIND_REPLY) begin
                n_out_byte   = 8'd0;
                n_out_last   = 1'b0;
                n_out_value  = r_gen_value;
                n_out_status = r_gen_status;
            end else if (r_gen_left == 4'd1) begin
                n_out_byte   = r_gen_crc;
                n_out_last   = 1'b1;
                n_out_value  = 32'd0;
                n_out_status = ST_OK;
            end else begin
                n_out_byte   = r_gen_buf[55:48];
                n_out_last   = 1'b0;
                n_out_value  = 32'd0;
                n_out_status = ST_OK;
                n_gen_buf    = {r_gen_buf[47:0], 8'd0};
                n_gen_crc    = crc8_feed(r_gen_crc, r_gen_buf[55:48]);
            end
        end

        if (in_fire) begin
            case (t_action'(i_s_axis_tuser))
                ACT_WRITE: begin
                    n_gen_left = 4'd8;
                    n_gen_kind = KIND_TX;
                    n_gen_buf  = {SYNC_BYTE, r_node, WRITE_FLAG, in_reg, in_value};
                    n_gen_crc  = 8'd0;
                end
                ACT_READ: begin
                    n_gen_left    = 4'd4;
                    n_gen_kind    = KIND_TX;
                    n_gen_buf     = {SYNC_BYTE, r_node, 1'b0, in_reg, 32'd0};
                    n_gen_crc     = 8'd0;
                    n_expected    = in_reg;
                    n_reply_count = 3'd0;
                    n_reply_crc   = 8'd0;
                    n_reply_data  = 32'd0;
                    n_reply_error = ST_OK;
                end
                ACT_REPLY: begin
                    if (r_reply_count != 3'd7) begin
                        n_gen_left = 4'd0;
                        if (r_reply_error == ST_OK) begin
                            if (r_reply_count == 3'd0 && in_rx != SYNC_BYTE) begin
                                n_reply_error = ST_BAD_SYNC;
                            end else if (r_reply_count == 3'd1 && in_rx != MASTER_ADDR) begin
                                n_reply_error = ST_BAD_MASTER;
                            end else if (r_reply_count == 3'd2 && in_rx != {1'b0, r_expected}) begin
                                n_reply_error = ST_BAD_REG;
                            end
                        end
                        if (r_reply_count >= 3'd3) begin
                            n_reply_data = {r_reply_data[23:0], in_rx};
                        end
                        n_reply_crc   = crc8_feed(r_reply_crc, in_rx);
                        n_reply_count = r_reply_count + 3'd1;
                    end else begin
                        if (r_reply_error == ST_OK && in_rx != r_reply_crc) begin
                            chk_status = ST_BAD_CRC;
                        end
                        n_gen_left    = 4'd1;
                        n_gen_kind    = KIND_REPLY;
                        n_gen_status  = chk_status;
                        n_gen_value   = (chk_status == ST_OK) ? r_reply_data : 32'd0;
                        n_reply_count = 3'd0;
                        n_reply_crc   = 8'd0;
                        n_reply_data  = 32'd0;
                        n_reply_error = ST_OK;
                    end
                end
                default: begin
                    // unused action: no result, state kept
                    n_gen_left = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node        <= 8'd0;
            r_reply_count <= 3'd0;
            r_reply_crc   <= 8'd0;
            r_reply_data  <= 32'd0;
            r_reply_error <= ST_OK;
            r_expected    <= 7'd0;
            r_gen_left    <= 4'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_node <= i_cfg_data;
            end
            r_reply_count <= n_reply_count;
            r_reply_crc   <= n_reply_crc;
            r_reply_data  <= n_reply_data;
            r_reply_error <= n_reply_error;
            r_expected    <= n_expected;
            r_gen_left    <= n_gen_left;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gen_kind   <= n_gen_kind;
        r_gen_buf    <= n_gen_buf;
        r_gen_crc    <= n_gen_crc;
        r_gen_value  <= n_gen_value;
        r_gen_status <= n_gen_status;
        r_out_kind   <= n_out_kind;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire

### design/uartrdc_chk.sv
// Port-level checker for the UART register datagram codec, bound to the top level.
// Depends on uart_register_datagram_codec_assert.svh and uartrdc_pkg.
`default_nettype none
`include "uart_register_datagram_codec_assert.svh"

module uartrdc_chk (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 o_m_axis_tvalid,
    input wire                                 i_m_axis_tready,
    input wire [uartrdc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire [0:0]                           o_m_axis_tuser,
    input wire                                 o_m_axis_tlast
);
    import uartrdc_pkg::*;

    `URDC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")
    `URDC_ASSERT_NOW(a_reply_no_last, o_m_axis_tvalid && o_m_axis_tuser[0] == KIND_REPLY, !o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'd0, "reply check carries a tx byte")
    `URDC_ASSERT_NOW(a_tx_no_reply, o_m_axis_tvalid && o_m_axis_tuser[0] == KIND_TX, o_m_axis_tdata[42:8] == 35'd0, "tx byte carries reply fields")
    `URDC_ASSERT_NOW(a_err_zero_value, o_m_axis_tvalid && o_m_axis_tdata[42:40] != 3'd0, o_m_axis_tdata[39:8] == 32'd0 && o_m_axis_tdata[42:40] <= 3'd4, "bad reply status or nonzero value on error")

endmodule

bind uart_register_datagram_codec uartrdc_chk u_uartrdc_chk (.*);

`default_nettype wire
